### design/tsq_pkg.sv
// Shared constants and codes for the task slot queue and periodic dispatch block.
package tsq_pkg;

    localparam int SLOTS_DEF = 16;

    localparam logic [15:0] FREE_MARK = 16'hFFFF;
    localparam logic [15:0] PRIO_CAP  = 16'hFFFE;

    // request codes
    localparam logic [1:0] REQ_QUEUE = 2'd0;
    localparam logic [1:0] REQ_SCHED = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;
    localparam logic [1:0] REQ_NOP   = 2'd3;

    // pop modes
    localparam logic [1:0] POP_BACK  = 2'd0;
    localparam logic [1:0] POP_FRONT = 2'd1;

    // result kinds
    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_SCHED = 2'd1;
    localparam logic [1:0] KIND_QUEUE = 2'd2;
    localparam logic [1:0] KIND_DONE  = 2'd3;

    // push status
    localparam logic [1:0] ST_Q_HEAD   = 2'd0;
    localparam logic [1:0] ST_Q_APPEND = 2'd1;
    localparam logic [1:0] ST_Q_FULL   = 2'd2;
    localparam logic [1:0] ST_S_MERGED = 2'd0;
    localparam logic [1:0] ST_S_ATTACH = 2'd1;
    localparam logic [1:0] ST_S_NEW    = 2'd2;
    localparam logic [1:0] ST_S_FULL   = 2'd3;

endpackage

### design/tsq_if.sv
// Request and result channel interfaces.
interface tsq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  task_id;
    logic [15:0] priority_req;
    logic [15:0] run_period;
    logic [15:0] repeat_count;
    logic [1:0]  pop_mode;
    logic [31:0] now;

    modport source (output valid, req_type, task_id, priority_req, run_period,
                    repeat_count, pop_mode, now, input ready);
    modport sink   (input valid, req_type, task_id, priority_req, run_period,
                    repeat_count, pop_mode, now, output ready);
endinterface

interface tsq_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [1:0]  status;
    logic [7:0]  task_id_res;
    logic [15:0] task_priority;
    logic        last;

    modport source (output valid, result_kind, status, task_id_res, task_priority, last,
                    input ready);
    modport sink   (input valid, result_kind, status, task_id_res, task_priority, last,
                    output ready);
endinterface

### design/task_slot_queue_and_periodic_dispatch.sv
// One transaction at a time: a push scans the slots, walks the queue links on an append
// and then returns its status; a tick scans every slot for due entries, walks to the
// queue tail on a LIFO pop, and then finishes; a stalled result side holds any step that
// emits a result. Every step goes through the single read port of the slot memory,
// whose read data is registered.
// All slot entries read as free right after reset; no clearing pass is needed.
module task_slot_queue_and_periodic_dispatch #(
    parameter int SLOTS = tsq_pkg::SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tsq_req_if.sink     req_ch,
    tsq_res_if.source   res_ch
);

    localparam int IW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS + 1);
    localparam logic [LW-1:0] NIL     = {LW{1'b1}};
    localparam logic [LW-1:0] SLOTS_L = LW'(SLOTS);
    localparam logic [IW-1:0] LAST_IX = IW'(SLOTS - 1);

    typedef struct packed {
        logic [7:0]    tid;
        logic [15:0]   prio;
        logic [LW-1:0] nxt;
        logic [15:0]   period;
        logic [15:0]   count;
        logic [31:0]   due;
    } rec_t;

    localparam rec_t REC_RST = '{tid: 8'd0, prio: tsq_pkg::FREE_MARK, nxt: NIL,
                                 period: 16'd0, count: 16'd0, due: 32'd0};

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_NEW_RD, S_NEW_WR, S_WALK_RD, S_WALK_CHK,
        S_POP_RD, S_POP_CHK, S_PREV_RD, S_PREV_WR, S_RESP, S_DONE
    } state_t;

    state_t        state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] fidx_reg, fidx_next;
    logic          ffound_reg, ffound_next;
    logic [LW-1:0] cur_reg, cur_next;
    logic [LW-1:0] prev_reg, prev_next;
    logic [LW-1:0] steps_reg, steps_next;
    logic [LW-1:0] head_reg, head_next;
    logic [1:0]    st_reg, st_next;

    logic [1:0]    req_reg, req_next;
    logic [7:0]    tid_reg, tid_next;
    logic [15:0]   prio_reg, prio_next;
    logic [15:0]   per_reg, per_next;
    logic [15:0]   cnt_reg, cnt_next;
    logic [1:0]    pop_reg, pop_next;
    logic [31:0]   now_reg, now_next;

    logic          ov_reg, ov_next;
    logic [1:0]    okind_reg, okind_next;
    logic [1:0]    ost_reg, ost_next;
    logic [7:0]    otid_reg, otid_next;
    logic [15:0]   oprio_reg, oprio_next;
    logic          olast_reg, olast_next;

    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic          wr_en;
    rec_t          rec;
    rec_t          wr_data;
    logic [$bits(rec_t)-1:0] rd_raw;

    logic          emit_ok;
    logic          rec_free;
    logic          last_ix;
    logic          adv;
    logic          sched_match;
    logic [16:0]   sat_sum;
    logic [15:0]   sat_cnt;
    logic [31:0]   due_new;

    tsq_slot_mem #(
        .DEPTH   (SLOTS),
        .DW      ($bits(rec_t)),
        .RST_VAL (REC_RST)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_raw),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign rec      = rec_t'(rd_raw);
    assign emit_ok  = !ov_reg || res_ch.ready;
    assign rec_free = (rec.prio == tsq_pkg::FREE_MARK) && (rec.count == 16'd0);
    assign last_ix  = (idx_reg == LAST_IX);
    assign sat_sum  = {1'b0, rec.count} + {1'b0, cnt_reg};
    assign sat_cnt  = sat_sum[16] ? 16'hFFFF : sat_sum[15:0];
    assign due_new  = {16'd0, per_reg} + now_reg;
    assign sched_match = (rec.tid == tid_reg) &&
                         ((rec.period == per_reg) || (rec.period == 16'd0));

    assign req_ch.ready         = (state_reg == S_IDLE);
    assign res_ch.valid         = ov_reg;
    assign res_ch.result_kind   = okind_reg;
    assign res_ch.status        = ost_reg;
    assign res_ch.task_id_res   = otid_reg;
    assign res_ch.task_priority = oprio_reg;
    assign res_ch.last          = olast_reg;

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        fidx_next   = fidx_reg;
        ffound_next = ffound_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        steps_next  = steps_reg;
        head_next   = head_reg;
        st_next     = st_reg;
        req_next    = req_reg;
        tid_next    = tid_reg;
        prio_next   = prio_reg;
        per_next    = per_reg;
        cnt_next    = cnt_reg;
        pop_next    = pop_reg;
        now_next    = now_reg;
        ov_next     = ov_reg && !res_ch.ready;
        okind_next  = okind_reg;
        ost_next    = ost_reg;
        otid_next   = otid_reg;
        oprio_next  = oprio_reg;
        olast_next  = olast_reg;
        rd_addr     = idx_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = rec;
        adv         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_ch.valid)
                begin
                    req_next    = req_ch.req_type;
                    tid_next    = req_ch.task_id;
                    prio_next   = req_ch.priority_req;
                    per_next    = req_ch.run_period;
                    cnt_next    = req_ch.repeat_count;
                    pop_next    = req_ch.pop_mode;
                    now_next    = req_ch.now;
                    idx_next    = '0;
                    ffound_next = 1'b0;
                    if (req_ch.req_type != tsq_pkg::REQ_NOP)
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                case (req_reg)
                    tsq_pkg::REQ_QUEUE:
                    begin
                        if (rec_free)
                        begin
                            wr_en        = 1'b1;
                            wr_data.nxt  = NIL;
                            wr_data.prio = (prio_reg == tsq_pkg::FREE_MARK) ?
                                           tsq_pkg::PRIO_CAP : prio_reg;
                            wr_data.tid  = tid_reg;
                            fidx_next    = idx_reg;
                            if (head_reg >= SLOTS_L)
                            begin
                                head_next  = LW'(idx_reg);
                                st_next    = tsq_pkg::ST_Q_HEAD;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                cur_next   = head_reg;
                                steps_next = '0;
                                st_next    = tsq_pkg::ST_Q_APPEND;
                                state_next = S_WALK_RD;
                            end
                        end
                        else if (last_ix)
                        begin
                            st_next    = tsq_pkg::ST_Q_FULL;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = S_SCAN_RD;
                        end
                    end
                    tsq_pkg::REQ_SCHED:
                    begin
                        if (sched_match)
                        begin
                            wr_en         = 1'b1;
                            wr_data.count = sat_cnt;
                            if (rec.period == per_reg)
                            begin
                                st_next = tsq_pkg::ST_S_MERGED;
                            end
                            else
                            begin
                                wr_data.period = per_reg;
                                wr_data.due    = due_new;
                                st_next        = tsq_pkg::ST_S_ATTACH;
                            end
                            state_next = S_RESP;
                        end
                        else
                        begin
                            if (rec_free && !ffound_reg)
                            begin
                                ffound_next = 1'b1;
                                fidx_next   = idx_reg;
                            end
                            if (last_ix)
                            begin
                                if (ffound_reg || rec_free)
                                begin
                                    state_next = S_NEW_RD;
                                end
                                else
                                begin
                                    st_next    = tsq_pkg::ST_S_FULL;
                                    state_next = S_RESP;
                                end
                            end
                            else
                            begin
                                idx_next   = idx_reg + 1'b1;
                                state_next = S_SCAN_RD;
                            end
                        end
                    end
                    default:
                    begin
                        if ((rec.count != 16'd0) && (rec.due <= now_reg))
                        begin
                            if (emit_ok)
                            begin
                                ov_next       = 1'b1;
                                okind_next    = tsq_pkg::KIND_SCHED;
                                ost_next      = 2'd0;
                                otid_next     = rec.tid;
                                oprio_next    = 16'd0;
                                olast_next    = 1'b0;
                                wr_en         = 1'b1;
                                wr_data.count = rec.count - 16'd1;
                                if (rec.count != 16'd1)
                                begin
                                    wr_data.due = {16'd0, rec.period} + now_reg;
                                end
                                adv = 1'b1;
                            end
                        end
                        else
                        begin
                            adv = 1'b1;
                        end
                        if (adv)
                        begin
                            if (!last_ix)
                            begin
                                idx_next   = idx_reg + 1'b1;
                                state_next = S_SCAN_RD;
                            end
                            else if (((pop_reg == tsq_pkg::POP_BACK) ||
                                      (pop_reg == tsq_pkg::POP_FRONT)) &&
                                     (head_reg < SLOTS_L))
                            begin
                                cur_next   = head_reg;
                                prev_next  = NIL;
                                steps_next = '0;
                                state_next = S_POP_RD;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                    end
                endcase
            end
            S_NEW_RD:
            begin
                rd_addr    = fidx_reg;
                state_next = S_NEW_WR;
            end
            S_NEW_WR:
            begin
                rd_addr        = fidx_reg;
                wr_en          = 1'b1;
                wr_addr        = fidx_reg;
                wr_data.count  = cnt_reg;
                wr_data.period = per_reg;
                wr_data.due    = due_new;
                wr_data.tid    = tid_reg;
                st_next        = tsq_pkg::ST_S_NEW;
                state_next     = S_RESP;
            end
            S_WALK_RD:
            begin
                rd_addr    = cur_reg[IW-1:0];
                state_next = S_WALK_CHK;
            end
            S_WALK_CHK:
            begin
                rd_addr = cur_reg[IW-1:0];
                if ((rec.nxt < SLOTS_L) && (steps_reg < SLOTS_L))
                begin
                    cur_next   = rec.nxt;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_WALK_RD;
                end
                else
                begin
                    if (cur_reg != LW'(fidx_reg))
                    begin
                        wr_en       = 1'b1;
                        wr_addr     = cur_reg[IW-1:0];
                        wr_data.nxt = LW'(fidx_reg);
                    end
                    state_next = S_RESP;
                end
            end
            S_POP_RD:
            begin
                rd_addr    = cur_reg[IW-1:0];
                state_next = S_POP_CHK;
            end
            S_POP_CHK:
            begin
                rd_addr = cur_reg[IW-1:0];
                if ((pop_reg == tsq_pkg::POP_BACK) && (rec.nxt < SLOTS_L) &&
                    (steps_reg < SLOTS_L))
                begin
                    prev_next  = cur_reg;
                    cur_next   = rec.nxt;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_POP_RD;
                end
                else if (emit_ok)
                begin
                    ov_next      = 1'b1;
                    okind_next   = tsq_pkg::KIND_QUEUE;
                    ost_next     = 2'd0;
                    otid_next    = rec.tid;
                    oprio_next   = rec.prio;
                    olast_next   = 1'b0;
                    wr_en        = 1'b1;
                    wr_addr      = cur_reg[IW-1:0];
                    wr_data.prio = tsq_pkg::FREE_MARK;
                    wr_data.nxt  = NIL;
                    if ((pop_reg == tsq_pkg::POP_BACK) && (prev_reg < SLOTS_L))
                    begin
                        state_next = S_PREV_RD;
                    end
                    else
                    begin
                        head_next  = (rec.nxt < SLOTS_L) ? rec.nxt : NIL;
                        state_next = S_DONE;
                    end
                end
            end
            S_PREV_RD:
            begin
                rd_addr    = prev_reg[IW-1:0];
                state_next = S_PREV_WR;
            end
            S_PREV_WR:
            begin
                rd_addr     = prev_reg[IW-1:0];
                wr_en       = 1'b1;
                wr_addr     = prev_reg[IW-1:0];
                wr_data.nxt = NIL;
                state_next  = S_DONE;
            end
            S_RESP:
            begin
                if (emit_ok)
                begin
                    ov_next    = 1'b1;
                    okind_next = tsq_pkg::KIND_PUSH;
                    ost_next   = st_reg;
                    otid_next  = 8'd0;
                    oprio_next = 16'd0;
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DONE:
            begin
                if (emit_ok)
                begin
                    ov_next    = 1'b1;
                    okind_next = tsq_pkg::KIND_DONE;
                    ost_next   = pop_reg;
                    otid_next  = 8'd0;
                    oprio_next = 16'd0;
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= NIL;
            ov_reg     <= 1'b0;
            idx_reg    <= '0;
            ffound_reg <= 1'b0;
            steps_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            ov_reg     <= ov_next;
            idx_reg    <= idx_next;
            ffound_reg <= ffound_next;
            steps_reg  <= steps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fidx_reg  <= fidx_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        st_reg    <= st_next;
        req_reg   <= req_next;
        tid_reg   <= tid_next;
        prio_reg  <= prio_next;
        per_reg   <= per_next;
        cnt_reg   <= cnt_next;
        pop_reg   <= pop_next;
        now_reg   <= now_next;
        okind_reg <= okind_next;
        ost_reg   <= ost_next;
        otid_reg  <= otid_next;
        oprio_reg <= oprio_next;
        olast_reg <= olast_next;
    end

`ifndef ASSERT_OFF
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == NIL) || (head_reg < SLOTS_L))
        else $error("queue head out of range");

    a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        steps_reg <= SLOTS_L)
        else $error("queue walk ran past slot count");

    a_walk_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK_RD) |-> (head_reg < SLOTS_L))
        else $error("append walk with empty queue");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !res_ch.ready) |=> ($stable(okind_reg) && $stable(otid_reg) &&
                                      $stable(olast_reg)))
        else $error("pending result overwritten");
`endif

endmodule

### design/tsq_slot_mem.sv
// Slot record memory: one write port, one registered read port, per-entry valid bits.
module tsq_slot_mem #(
    parameter int              DEPTH   = 16,
    parameter int              DW      = 8,
    parameter logic [DW-1:0]   RST_VAL = '0,
    localparam int             AW      = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [DW-1:0]    rd_q_reg;
    logic             rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    // entries never written read as their reset record
    assign rd_data = rd_vld_reg ? rd_q_reg : RST_VAL;

endmodule

### bench/tsq_tb_if.sv
`timescale 1ns / 100ps
// Result record type used by the testbench scoreboard.
package tsq_tb_types;
    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [7:0]  task_id;
        logic [15:0] prio;
        logic        last;
    } dispatch_t;
endpackage

### bench/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the task slot queue and periodic dispatch block.
module tb_top;

    localparam int NSLOT = 16;
    localparam logic [5:0] NULL_LINK = 6'd63;
    localparam logic [1:0] POP_NONE = 2'd2;
    localparam logic [1:0] POP_BAD = 2'd3;
    localparam int CYCLE_LIMIT = 1500000;

    logic clk = 1'b0;
    logic rst_n;
    tsq_req_if req_ch ();
    tsq_res_if res_ch ();

    task_slot_queue_and_periodic_dispatch #(.SLOTS(NSLOT)) u_top (
        .clk(clk), .rst_n(rst_n), .req_ch(req_ch.sink), .res_ch(res_ch.source)
    );

    // predictor state
    logic [7:0]  m_task [NSLOT];
    logic [15:0] m_prio [NSLOT];
    logic [5:0]  m_next [NSLOT];
    logic [15:0] m_period [NSLOT];
    logic [15:0] m_count [NSLOT];
    logic [31:0] m_due [NSLOT];
    logic [5:0]  m_head;

    tsq_tb_types::dispatch_t expected_q[$];
    int errors = 0;
    int cycles = 0;
    int stall_left = 0;
    bit allow_idle = 1;
    bit hold_sink = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic bit is_link(logic [5:0] v);
        return v < NSLOT;
    endfunction

    function automatic bit slot_is_free(int i);
        return m_prio[i] == tsq_pkg::FREE_MARK && m_count[i] == 16'd0;
    endfunction

    function automatic logic [5:0] lowest_free();
        for (int i = 0; i < NSLOT; i++)
            if (slot_is_free(i))
                return i[5:0];
        return NULL_LINK;
    endfunction

    function automatic logic [15:0] add_sat(logic [15:0] a, logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    task automatic add_expect(logic [1:0] k, logic [1:0] st, logic [7:0] t, logic [15:0] p);
        tsq_tb_types::dispatch_t d;
        d.kind = k; d.status = st; d.task_id = t; d.prio = p; d.last = 1'b0;
        expected_q.push_back(d);
    endtask

    task automatic pop_slot(bit from_tail);
        logic [5:0] cur, prev;
        int steps;
        cur = m_head; prev = NULL_LINK; steps = 0;
        if (!is_link(cur))
            return;
        if (from_tail)
            while (is_link(m_next[cur]) && steps < NSLOT)
            begin
                prev = cur;
                cur = m_next[cur];
                steps++;
            end
        add_expect(tsq_pkg::KIND_QUEUE, 2'd0, m_task[cur], m_prio[cur]);
        m_prio[cur] = tsq_pkg::FREE_MARK;
        if (from_tail && is_link(prev))
            m_next[prev] = NULL_LINK;
        else
            m_head = is_link(m_next[cur]) ? m_next[cur] : NULL_LINK;
        m_next[cur] = NULL_LINK;
    endtask

    task automatic predict_request(logic [1:0] rq, logic [7:0] t, logic [15:0] p,
                                   logic [15:0] per, logic [15:0] cnt, logic [1:0] pm,
                                   logic [31:0] tnow);
        logic [5:0] i, cur;
        logic [1:0] st;
        int steps, n0;
        n0 = expected_q.size();
        if (rq == tsq_pkg::REQ_QUEUE)
        begin
            i = lowest_free();
            if (!is_link(i))
                st = tsq_pkg::ST_Q_FULL;
            else
            begin
                m_next[i] = NULL_LINK;
                m_prio[i] = (p == tsq_pkg::FREE_MARK) ? tsq_pkg::PRIO_CAP : p;
                m_task[i] = t;
                if (!is_link(m_head))
                begin
                    m_head = i;
                    st = tsq_pkg::ST_Q_HEAD;
                end
                else
                begin
                    cur = m_head; steps = 0;
                    while (is_link(m_next[cur]) && steps < NSLOT)
                    begin
                        cur = m_next[cur];
                        steps++;
                    end
                    if (cur != i)
                        m_next[cur] = i;
                    st = tsq_pkg::ST_Q_APPEND;
                end
            end
            add_expect(tsq_pkg::KIND_PUSH, st, 8'd0, 16'd0);
        end
        else if (rq == tsq_pkg::REQ_SCHED)
        begin
            st = tsq_pkg::ST_S_FULL;
            for (int s = 0; s < NSLOT; s++)
            begin
                if (m_task[s] != t)
                    continue;
                if (m_period[s] == per)
                begin
                    m_count[s] = add_sat(m_count[s], cnt);
                    st = tsq_pkg::ST_S_MERGED;
                    break;
                end
                if (m_period[s] == 16'd0)
                begin
                    m_period[s] = per;
                    m_count[s] = add_sat(m_count[s], cnt);
                    m_due[s] = {16'd0, per} + tnow;
                    st = tsq_pkg::ST_S_ATTACH;
                    break;
                end
            end
            if (st == tsq_pkg::ST_S_FULL)
            begin
                i = lowest_free();
                if (is_link(i))
                begin
                    m_count[i] = cnt;
                    m_period[i] = per;
                    m_due[i] = {16'd0, per} + tnow;
                    m_task[i] = t;
                    st = tsq_pkg::ST_S_NEW;
                end
            end
            add_expect(tsq_pkg::KIND_PUSH, st, 8'd0, 16'd0);
        end
        else if (rq == tsq_pkg::REQ_TICK)
        begin
            for (int s = 0; s < NSLOT; s++)
                if (m_count[s] != 16'd0 && m_due[s] <= tnow)
                begin
                    add_expect(tsq_pkg::KIND_SCHED, 2'd0, m_task[s], 16'd0);
                    m_count[s] = m_count[s] - 16'd1;
                    if (m_count[s] != 16'd0)
                        m_due[s] = {16'd0, m_period[s]} + tnow;
                end
            if (pm == tsq_pkg::POP_BACK)
                pop_slot(1);
            else if (pm == tsq_pkg::POP_FRONT)
                pop_slot(0);
            add_expect(tsq_pkg::KIND_DONE, pm, 8'd0, 16'd0);
        end
        if (expected_q.size() > n0)
            expected_q[expected_q.size() - 1].last = 1'b1;
    endtask

    // valid stays high from one transaction into the next unless an idle burst comes between
    task automatic send_request(logic [1:0] rq, logic [7:0] t, logic [15:0] p,
                                logic [15:0] per, logic [15:0] cnt, logic [1:0] pm,
                                logic [31:0] tnow);
        int gap;
        if (allow_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 15);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= rq;
        req_ch.task_id <= t;
        req_ch.priority_req <= p;
        req_ch.run_period <= per;
        req_ch.repeat_count <= cnt;
        req_ch.pop_mode <= pm;
        req_ch.now <= tnow;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predict_request(rq, t, p, per, cnt, pm, tnow);
    endtask

    // result checker
    always @(posedge clk)
    begin
        tsq_tb_types::dispatch_t e;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result kind=%0d status=%0d task=%0d prio=%0d last=%0d",
                         $time, res_ch.result_kind, res_ch.status, res_ch.task_id_res,
                         res_ch.task_priority, res_ch.last);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (e.kind !== res_ch.result_kind || e.status !== res_ch.status
                    || e.task_id !== res_ch.task_id_res || e.prio !== res_ch.task_priority
                    || e.last !== res_ch.last)
                begin
                    $display("%0t: mismatch expected kind=%0d status=%0d task=%0d prio=%0d",
                             $time, e.kind, e.status, e.task_id, e.prio);
                    $display("%0t:          expected last=%0d", $time, e.last);
                    $display("%0t:          actual   kind=%0d status=%0d task=%0d prio=%0d",
                             $time, res_ch.result_kind, res_ch.status, res_ch.task_id_res,
                             res_ch.task_priority);
                    $display("%0t:          actual   last=%0d", $time, res_ch.last);
                    errors++;
                end
            end
        end
    end

    // result side ready with stall bursts of random length and an optional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            stall_left <= 0;
        end
        else if (hold_sink)
            res_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (allow_idle && $urandom_range(0, 7) == 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left <= $urandom_range(0, 14);
        end
        else
            res_ch.ready <= 1'b1;
    end

    logic [31:0] clock_now = 32'd0;

    task automatic test_queue_push_pop();
        send_request(tsq_pkg::REQ_QUEUE, 8'd1, 16'd0, 16'd0, 16'd0, POP_NONE, clock_now);
        send_request(tsq_pkg::REQ_QUEUE, 8'd255, tsq_pkg::FREE_MARK, 16'hFFFF, 16'hFFFF,
                     POP_BAD, 32'hFFFFFFFF);
        send_request(tsq_pkg::REQ_QUEUE, 8'd0, 16'd1234, 16'd0, 16'd0, POP_NONE, clock_now);
        send_request(tsq_pkg::REQ_TICK, 8'd0, 16'd0, 16'd0, 16'd0, tsq_pkg::POP_BACK,
                     clock_now);
        send_request(tsq_pkg::REQ_TICK, 8'd0, 16'd0, 16'd0, 16'd0, tsq_pkg::POP_FRONT,
                     clock_now);
        send_request(tsq_pkg::REQ_TICK, 8'd0, 16'd0, 16'd0, 16'd0, POP_BAD, clock_now);
        send_request(tsq_pkg::REQ_TICK, 8'd0, 16'd0, 16'd0, 16'd0, tsq_pkg::POP_BACK,
                     clock_now);
        send_request(tsq_pkg::REQ_TICK, 8'd0, 16'd0, 16'd0, 16'd0, tsq_pkg::POP_BACK,
                     clock_now);
        send_request(tsq_pkg::REQ_NOP, 8'd7, 16'd7, 16'd7, 16'd7, tsq_pkg::POP_FRONT,
                     clock_now);
    endtask

    task automatic test_schedule();
        send_request(tsq_pkg::REQ_SCHED, 8'd10, 16'd0, 16'd5, 16'd3, POP_NONE, 32'd100);
        send_request(tsq_pkg::REQ_SCHED, 8'd10, 16'd0, 16'd5, 16'hFFFF, POP_NONE, 32'd100);
        send_request(tsq_pkg::REQ_SCHED, 8'd10, 16'd0, 16'd9, 16'd1, POP_NONE, 32'd100);
        // task 1's popped slot was reused above, so this takes a new slot
        send_request(tsq_pkg::REQ_SCHED, 8'd1, 16'd0, 16'd2, 16'd2, POP_NONE, 32'hFFFFFFFF);
        send_request(tsq_pkg::REQ_SCHED, 8'd20, 16'd0, 16'd0, 16'd0, POP_NONE, 32'd0);
        send_request(tsq_pkg::REQ_TICK, 8'd0, 16'd0, 16'd0, 16'd0, POP_NONE, 32'd105);
        send_request(tsq_pkg::REQ_TICK, 8'd0, 16'd0, 16'd0, 16'd0, tsq_pkg::POP_FRONT,
                     32'hFFFFFFFF);
        send_request(tsq_pkg::REQ_TICK, 8'd0, 16'd0, 16'd0, 16'd0, tsq_pkg::POP_FRONT,
                     32'd0);
        // fill the table until full
        for (int i = 0; i < 18; i++)
            send_request(tsq_pkg::REQ_QUEUE, 8'(i + 40), 16'(i), 16'd0, 16'd0, POP_NONE,
                         32'd0);
        send_request(tsq_pkg::REQ_SCHED, 8'd99, 16'd0, 16'd3, 16'd1, POP_NONE, 32'd0);
        for (int i = 0; i < 18; i++)
            send_request(tsq_pkg::REQ_TICK, 8'd0, 16'd0, 16'd0, 16'd0, 2'(i % 2), 32'd200);
    endtask

    task automatic test_random(int n);
        logic [1:0] rq, pm;
        logic [31:0] tnow;
        for (int i = 0; i < n; i++)
        begin
            clock_now = clock_now + $urandom_range(0, 6);
            tnow = ($urandom_range(0, 30) == 0) ? $urandom : clock_now;
            case ($urandom_range(0, 9))
                0, 1, 2: rq = tsq_pkg::REQ_QUEUE;
                3, 4:    rq = tsq_pkg::REQ_SCHED;
                9:       rq = ($urandom_range(0, 3) == 0) ? tsq_pkg::REQ_NOP : tsq_pkg::REQ_TICK;
                default: rq = tsq_pkg::REQ_TICK;
            endcase
            pm = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
            send_request(rq,
                         ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 12)),
                         ($urandom_range(0, 20) == 0) ? tsq_pkg::FREE_MARK : 16'($urandom),
                         ($urandom_range(0, 10) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8)),
                         ($urandom_range(0, 10) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4)),
                         pm, tnow);
        end
    endtask

    task automatic test_backpressure();
        hold_sink = 1;
        fork
            begin
                repeat (400) @(posedge clk);
                hold_sink = 0;
            end
            test_random(20);
        join
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = tsq_pkg::REQ_QUEUE;
        req_ch.task_id = 8'd0;
        req_ch.priority_req = 16'd0;
        req_ch.run_period = 16'd0;
        req_ch.repeat_count = 16'd0;
        req_ch.pop_mode = POP_NONE;
        req_ch.now = 32'd0;
        for (int i = 0; i < NSLOT; i++)
        begin
            m_task[i] = 8'd0; m_prio[i] = tsq_pkg::FREE_MARK; m_next[i] = NULL_LINK;
            m_period[i] = 16'd0; m_count[i] = 16'd0; m_due[i] = 32'd0;
        end
        m_head = NULL_LINK;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_queue_push_pop();
        test_schedule();
        test_backpressure();
        test_random(150);
        allow_idle = 0;
        test_random(60);
        req_ch.valid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
